>>> rtl/core/crcfr_pkg.sv
package crcfr_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CRC_W    = 16;
	localparam int unsigned NUM_CODES = 5;
	localparam int unsigned CODES_W  = NUM_CODES * BYTE_W;
	localparam int unsigned APB_DW   = 64;
	localparam int unsigned APB_AW   = 6;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

	// register index, taken from paddr[5:3]
	typedef enum logic [2:0] {
		REG_SYNC     = 3'd0,
		REG_LOCAL    = 3'd1,
		REG_SRC_A    = 3'd2,
		REG_SRC_B    = 3'd3,
		REG_FN_CODES = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_SOURCE   = 3'd1,
		PH_TARGET   = 3'd2,
		PH_FUNCTION = 3'd3,
		PH_DADDR    = 3'd4,
		PH_DATA     = 3'd5,
		PH_CRC      = 3'd6,
		PH_RECOVER  = 3'd7
	} phase_t;

	// CRC-16/Modbus, one byte, LSB first
	function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
	                                                input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/core/crcfr_ifs.sv
interface crcfr_rx_if;
	import crcfr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcfr_res_if;
	import crcfr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] source_address;
	logic [BYTE_W-1:0] function_code;
	logic [BYTE_W-1:0] data_address;
	logic [BYTE_W-1:0] data_value;
	logic              has_data;
	logic              crc_ok;

	modport source (output valid, output source_address, output function_code,
	                output data_address, output data_value, output has_data,
	                output crc_ok, input ready);
	modport sink   (input valid, input source_address, input function_code,
	                input data_address, input data_value, input has_data,
	                input crc_ok, output ready);
endinterface

>>> rtl/core/crc16_addressed_frame_receiver_top.sv
// Addressed frame receiver with CRC-16/Modbus check.
// rx_chan (valid/ready) takes one received byte per transaction. The block
// hunts for frames: sync, source, target, function, data address, optional
// data byte, then the CRC (low byte first) over all earlier frame bytes.
// res_chan carries one transaction per completed frame with its fields,
// has_data and crc_ok; frames with a bad source or target give nothing.
// Configuration goes through the APB port: 64-bit data, register i at byte
// address 8*i (sync, local address, source A, source B, packed function
// codes). Writes are meant to happen while the block is idle.
// A byte in the input register is parsed when the result register has room; a
// frame's result is valid right after the edge that parses its last CRC byte.
// Throughput: one byte per cycle unless res_chan stalls. The input register
// feeds the parser and the result register through compare/CRC logic.
// Stall: while res_chan holds a result that is not taken, the parser pauses
// on the byte in the input register; if it is full, rx_chan.ready drops
// combinationally with res_chan.ready until the result is taken.
// Reset (arst_n low): configuration registers clear to zero, parser hunts
// for a header, running CRC returns to 0xFFFF, no results pending.
module crc16_addressed_frame_receiver_top (
	input  logic                         clk,
	input  logic                         arst_n,
	crcfr_rx_if.sink                     rx_chan,
	crcfr_res_if.source                  res_chan,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [crcfr_pkg::APB_AW-1:0] paddr,
	input  logic [crcfr_pkg::APB_DW-1:0] pwdata,
	output logic [crcfr_pkg::APB_DW-1:0] prdata,
	output logic                         pready
);
	import crcfr_pkg::*;

	// configuration registers
	logic [BYTE_W-1:0]  sync_byte_q;
	logic [BYTE_W-1:0]  local_address_q;
	logic [BYTE_W-1:0]  source_a_q;
	logic [BYTE_W-1:0]  source_b_q;
	logic [CODES_W-1:0] fn_codes_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q     <= '0;
			local_address_q <= '0;
			source_a_q      <= '0;
			source_b_q      <= '0;
			fn_codes_q      <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_SYNC:     sync_byte_q     <= pwdata[BYTE_W-1:0];
				REG_LOCAL:    local_address_q <= pwdata[BYTE_W-1:0];
				REG_SRC_A:    source_a_q      <= pwdata[BYTE_W-1:0];
				REG_SRC_B:    source_b_q      <= pwdata[BYTE_W-1:0];
				REG_FN_CODES: fn_codes_q      <= pwdata[CODES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_SYNC:     prdata = {{(APB_DW-BYTE_W){1'b0}}, sync_byte_q};
			REG_LOCAL:    prdata = {{(APB_DW-BYTE_W){1'b0}}, local_address_q};
			REG_SRC_A:    prdata = {{(APB_DW-BYTE_W){1'b0}}, source_a_q};
			REG_SRC_B:    prdata = {{(APB_DW-BYTE_W){1'b0}}, source_b_q};
			REG_FN_CODES: prdata = {{(APB_DW-CODES_W){1'b0}}, fn_codes_q};
			default:      prdata = '0;
		endcase
	end

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] rx_s1;
	logic              proc_en;
	logic              out_valid_q;

	// parse the held byte only when the result register has room
	assign proc_en       = valid_s1 & (~out_valid_q | res_chan.ready);
	assign rx_chan.ready = ~valid_s1 | proc_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_chan.ready) begin
			valid_s1 <= rx_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_chan.valid && rx_chan.ready) begin
			rx_s1 <= rx_chan.rx_byte;
		end
	end

	// parser state
	phase_t            phase_q, phase_d;
	logic [CRC_W-1:0]  crc_q, crc_d;
	logic [BYTE_W-1:0] rcv_lo_q, rcv_lo_d;   // first CRC byte of the frame
	logic              seen_q, seen_d;
	logic              needs_q, needs_d;
	logic [BYTE_W-1:0] src_q, src_d;
	logic [BYTE_W-1:0] fn_q, fn_d;
	logic [BYTE_W-1:0] daddr_q, daddr_d;
	logic [BYTE_W-1:0] data_q, data_d;

	logic is_sync, src_hit, tgt_hit, code_hit, crc_match;

	assign is_sync   = (rx_s1 == sync_byte_q);
	assign src_hit   = (rx_s1 == source_a_q) || (rx_s1 == source_b_q);
	assign tgt_hit   = (rx_s1 == local_address_q);
	assign crc_match = ({rx_s1, rcv_lo_q} == crc_q);

	always_comb begin
		code_hit = 1'b0;
		for (int k = 0; k < NUM_CODES; k++) begin
			if (fn_codes_q[k*BYTE_W +: BYTE_W] == rx_s1) begin
				code_hit = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		crc_d    = crc_q;
		rcv_lo_d = rcv_lo_q;
		seen_d   = seen_q;
		needs_d  = needs_q;
		src_d    = src_q;
		fn_d     = fn_q;
		daddr_d  = daddr_q;
		data_d   = data_q;
		unique case (phase_q)
			PH_HEADER, PH_RECOVER: begin
				if (is_sync) begin
					crc_d   = crc_update(CRC_INIT, rx_s1);
					seen_d  = 1'b0;
					phase_d = PH_SOURCE;
				end
			end
			PH_SOURCE: begin
				if (src_hit) begin
					src_d   = rx_s1;
					crc_d   = crc_update(crc_q, rx_s1);
					phase_d = PH_TARGET;
				end else if (is_sync) begin
					crc_d   = crc_update(CRC_INIT, rx_s1);
					seen_d  = 1'b0;
					phase_d = PH_SOURCE;
				end else begin
					phase_d = PH_HEADER;
				end
			end
			PH_TARGET: begin
				if (tgt_hit) begin
					crc_d   = crc_update(crc_q, rx_s1);
					phase_d = PH_FUNCTION;
				end else if (is_sync) begin
					crc_d   = crc_update(CRC_INIT, rx_s1);
					seen_d  = 1'b0;
					phase_d = PH_SOURCE;
				end else begin
					phase_d = PH_HEADER;
				end
			end
			PH_FUNCTION: begin
				fn_d    = rx_s1;
				needs_d = code_hit;
				crc_d   = crc_update(crc_q, rx_s1);
				phase_d = PH_DADDR;
			end
			PH_DADDR: begin
				daddr_d = rx_s1;
				crc_d   = crc_update(crc_q, rx_s1);
				if (needs_q) begin
					phase_d = PH_DATA;
				end else begin
					data_d  = '0;
					phase_d = PH_CRC;
				end
			end
			PH_DATA: begin
				data_d  = rx_s1;
				crc_d   = crc_update(crc_q, rx_s1);
				phase_d = PH_CRC;
			end
			PH_CRC: begin
				if (!seen_q) begin
					rcv_lo_d = rx_s1;
					seen_d   = 1'b1;
				end else begin
					seen_d   = 1'b0;
					crc_d    = CRC_INIT;
					phase_d  = crc_match ? PH_HEADER : PH_RECOVER;
				end
			end
			default: phase_d = PH_HEADER;
		endcase
	end

	// outputs of the parser: a frame ends on the second CRC byte
	logic res_fire;

	always_comb begin
		res_fire = (phase_q == PH_CRC) && seen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			crc_q    <= CRC_INIT;
			rcv_lo_q <= '0;
			seen_q   <= 1'b0;
			needs_q  <= 1'b0;
			src_q    <= '0;
			fn_q     <= '0;
			daddr_q  <= '0;
			data_q   <= '0;
		end else if (proc_en) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			rcv_lo_q <= rcv_lo_d;
			seen_q   <= seen_d;
			needs_q  <= needs_d;
			src_q    <= src_d;
			fn_q     <= fn_d;
			daddr_q  <= daddr_d;
			data_q   <= data_d;
		end
	end

	// result register
	logic [BYTE_W-1:0] res_src_q, res_fn_q, res_daddr_q, res_data_q;
	logic              res_has_q, res_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc_en && res_fire) begin
			out_valid_q <= 1'b1;
		end else if (res_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_en && res_fire) begin
			res_src_q   <= src_q;
			res_fn_q    <= fn_q;
			res_daddr_q <= daddr_q;
			res_data_q  <= needs_q ? data_q : '0;
			res_has_q   <= needs_q;
			res_ok_q    <= crc_match;
		end
	end

	assign res_chan.valid          = out_valid_q;
	assign res_chan.source_address = res_src_q;
	assign res_chan.function_code  = res_fn_q;
	assign res_chan.data_address   = res_daddr_q;
	assign res_chan.data_value     = res_data_q;
	assign res_chan.has_data       = res_has_q;
	assign res_chan.crc_ok         = res_ok_q;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import crcfr_pkg::*;

	// quiet cycles (nothing accepted on any port) before the run is declared hung
	localparam int unsigned QUIET_LIMIT = 2000;
	// first register index past the map; writes there must be dropped
	localparam int unsigned REG_COUNT = 5;
	// cap on printed mismatch lines
	localparam int unsigned MAX_REPORTS = 200;

	// settings used by the directed part
	localparam logic [7:0]  D_SYNC  = 8'hA5;
	localparam logic [7:0]  D_LOCAL = 8'h11;
	localparam logic [7:0]  D_SRC_A = 8'h01;
	localparam logic [7:0]  D_SRC_B = 8'h02;
	// 0x10 listed twice on purpose
	localparam logic [39:0] D_CODES = 40'h10_10_0F_06_05;

	typedef struct packed {
		logic [7:0] src;
		logic [7:0] fn;
		logic [7:0] daddr;
		logic [7:0] dval;
		logic       with_data;
		logic       crc_good;
	} frame_fields_t;

	// CRC-16/Modbus over one byte, reflected, LSB first
	function automatic logic [15:0] crc_byte_step(logic [15:0] acc, logic [7:0] d);
		logic [15:0] r;
		r = acc ^ {8'h00, d};
		repeat (8) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// Frame tracker: follows the parser byte by byte and queues the frame
	// reports the block owes, then checks each report against the oldest one.
	class frame_scoreboard;
		logic [7:0]  sync_byte;
		logic [7:0]  local_addr;
		logic [7:0]  src_a;
		logic [7:0]  src_b;
		logic [39:0] fn_codes;

		phase_t      ph;
		logic [15:0] run_crc;
		logic [15:0] rcv_crc;
		bit          crc_lo_seen;
		bit          with_data;
		logic [7:0]  h_src;
		logic [7:0]  h_fn;
		logic [7:0]  h_daddr;
		logic [7:0]  h_data;

		frame_fields_t expected_frames[$];
		int unsigned errors;
		int unsigned frames_good;
		int unsigned frames_bad;

		function new();
			sync_byte   = '0;
			local_addr  = '0;
			src_a       = '0;
			src_b       = '0;
			fn_codes    = '0;
			ph          = PH_HEADER;
			run_crc     = CRC_INIT;
			rcv_crc     = '0;
			crc_lo_seen = 0;
			with_data   = 0;
			h_src       = '0;
			h_fn        = '0;
			h_daddr     = '0;
			h_data      = '0;
			errors      = 0;
			frames_good = 0;
			frames_bad  = 0;
		endfunction

		function void write_reg(int unsigned idx, logic [63:0] v);
			case (idx)
				REG_SYNC:     sync_byte  = v[7:0];
				REG_LOCAL:    local_addr = v[7:0];
				REG_SRC_A:    src_a      = v[7:0];
				REG_SRC_B:    src_b      = v[7:0];
				REG_FN_CODES: fn_codes   = v[39:0];
				default: ;
			endcase
		endfunction

		function bit code_has_data(logic [7:0] c);
			for (int k = 0; k < NUM_CODES; k++) begin
				if (fn_codes[8*k +: 8] == c) return 1;
			end
			return 0;
		endfunction

		function void open_frame(logic [7:0] b);
			run_crc     = crc_byte_step(CRC_INIT, b);
			rcv_crc     = '0;
			crc_lo_seen = 0;
			ph          = PH_SOURCE;
		endfunction

		function void note_byte(logic [7:0] b);
			frame_fields_t f;
			case (ph)
				PH_HEADER, PH_RECOVER: begin
					if (b == sync_byte) open_frame(b);
				end
				PH_SOURCE: begin
					// an accepted source wins over a sync match
					if (b == src_a || b == src_b) begin
						h_src   = b;
						run_crc = crc_byte_step(run_crc, b);
						ph      = PH_TARGET;
					end else if (b == sync_byte) begin
						open_frame(b);
					end else begin
						ph = PH_HEADER;
					end
				end
				PH_TARGET: begin
					if (b == local_addr) begin
						run_crc = crc_byte_step(run_crc, b);
						ph      = PH_FUNCTION;
					end else if (b == sync_byte) begin
						open_frame(b);
					end else begin
						ph = PH_HEADER;
					end
				end
				PH_FUNCTION: begin
					h_fn      = b;
					with_data = code_has_data(b);
					run_crc   = crc_byte_step(run_crc, b);
					ph        = PH_DADDR;
				end
				PH_DADDR: begin
					h_daddr = b;
					run_crc = crc_byte_step(run_crc, b);
					if (with_data) begin
						ph = PH_DATA;
					end else begin
						h_data = '0;
						ph     = PH_CRC;
					end
				end
				PH_DATA: begin
					h_data  = b;
					run_crc = crc_byte_step(run_crc, b);
					ph      = PH_CRC;
				end
				default: begin
					if (!crc_lo_seen) begin
						rcv_crc     = {8'h00, b};
						crc_lo_seen = 1;
					end else begin
						rcv_crc[15:8] = b;
						f.src       = h_src;
						f.fn        = h_fn;
						f.daddr     = h_daddr;
						f.dval      = with_data ? h_data : 8'h00;
						f.with_data = with_data;
						f.crc_good  = (rcv_crc == run_crc);
						expected_frames.push_back(f);
						if (f.crc_good) frames_good++;
						else frames_bad++;
						crc_lo_seen = 0;
						rcv_crc     = '0;
						run_crc     = CRC_INIT;
						ph          = f.crc_good ? PH_HEADER : PH_RECOVER;
					end
				end
			endcase
		endfunction

		function void compare_field(string what, logic [7:0] exp_v, logic [7:0] got_v);
			if (exp_v !== got_v) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s mismatch: expected 0x%02h, got 0x%02h",
					         $time, what, exp_v, got_v);
			end
		endfunction

		function void check_result(frame_fields_t got);
			frame_fields_t want;
			if (expected_frames.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected frame report: expected none, %s",
					         $time, $sformatf("got src 0x%02h fn 0x%02h",
					         got.src, got.fn));
				return;
			end
			want = expected_frames.pop_front();
			compare_field("source_address", want.src, got.src);
			compare_field("function_code", want.fn, got.fn);
			compare_field("data_address", want.daddr, got.daddr);
			compare_field("data_value", want.dval, got.dval);
			compare_field("has_data", {7'd0, want.with_data}, {7'd0, got.with_data});
			compare_field("crc_ok", {7'd0, want.crc_good}, {7'd0, got.crc_good});
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	crcfr_rx_if  rx_if();
	crcfr_res_if res_if();

	frame_scoreboard sb = new();

	logic [7:0]  burst[$];      // bytes waiting to go out on the rx channel
	bit          no_gaps;       // when set, neither side idles
	int unsigned n_bytes;
	int unsigned n_settings;
	int unsigned quiet_cycles;
	int unsigned sink_stall;

	crc16_addressed_frame_receiver_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_chan  (rx_if),
		.res_chan (res_if),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// mostly back to back, sometimes a short gap, rarely a long pause
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result sink: random backpressure, switched off in no-gap stretches
	always @(negedge clk) begin
		if (sink_stall > 0 && !no_gaps) begin
			res_if.ready <= 1'b0;
			sink_stall--;
		end else begin
			res_if.ready <= 1'b1;
			sink_stall = 0;
			if (!no_gaps && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
		end
	end

	// every result transaction is checked against the oldest expected frame
	always @(posedge clk) begin
		frame_fields_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.src       = res_if.source_address;
			got.fn        = res_if.function_code;
			got.daddr     = res_if.data_address;
			got.dval      = res_if.data_value;
			got.with_data = res_if.has_data;
			got.crc_good  = res_if.crc_ok;
			sb.check_result(got);
		end
	end

	// hang detection: any transaction on any port resets the count
	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
		    (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d frames still expected",
			         $time, QUIET_LIMIT, sb.expected_frames.size());
			$display("[crc16_addressed_frame_receiver_top] ERROR");
			$finish;
		end
	end

	// one APB write, then an optional read back of the same register
	task automatic program_reg(int unsigned idx, logic [63:0] v, bit readback);
		logic [63:0] mask;
		mask = (idx == REG_FN_CODES) ? {24'h0, {40{1'b1}}} : 64'hFF;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(idx * 8);
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (readback) begin
			@(negedge clk);
			psel <= 1'b1;
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if ((prdata & mask) !== (v & mask)) begin
				sb.errors++;
				$display("%0t: register %0d read back: expected 0x%010h, got 0x%010h",
				         $time, idx, v & mask, prdata & mask);
			end
			@(negedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	// settings change only once the parser has nothing left in flight
	task automatic configure(logic [7:0] sync_v, logic [7:0] local_v, logic [7:0] src_a_v,
	                         logic [7:0] src_b_v, logic [39:0] codes_v);
		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (sb.expected_frames.size() != 0) @(posedge clk);
		// a byte that gives no result may still be in the input register
		repeat (4) @(posedge clk);
		program_reg(REG_SYNC, {56'h0, sync_v}, 1);
		program_reg(REG_LOCAL, {56'h0, local_v}, 1);
		program_reg(REG_SRC_A, {56'h0, src_a_v}, 1);
		program_reg(REG_SRC_B, {56'h0, src_b_v}, 1);
		program_reg(REG_FN_CODES, {24'h0, codes_v}, 1);
		// unmapped index: must leave every register alone
		program_reg(REG_COUNT, {$urandom, $urandom}, 0);
		n_settings++;
	endtask

	// valid stays up between back-to-back bytes; one transaction per call
	task automatic send_byte(logic [7:0] b);
		int unsigned gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			rx_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		sb.note_byte(b);
		n_bytes++;
	endtask

	task automatic send_burst();
		foreach (burst[i]) send_byte(burst[i]);
		burst.delete();
	endtask

	// append CRC (low byte first) over burst[first..end], optionally damaged
	function automatic void add_crc(int first, bit corrupt);
		logic [15:0] c;
		c = CRC_INIT;
		for (int i = first; i < burst.size(); i++) c = crc_byte_step(c, burst[i]);
		if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
		burst.push_back(c[7:0]);
		burst.push_back(c[15:8]);
	endfunction

	// mostly well-formed frames with random content; some noise in front,
	// some bad addresses, bad CRCs and cut-off tails
	function automatic void build_random_frame();
		int          first;
		int unsigned r;
		logic [7:0]  v;
		logic [7:0]  fn;
		if ($urandom_range(0, 99) < 30) begin
			repeat ($urandom_range(1, 3)) burst.push_back(8'($urandom));
		end
		first = burst.size();
		burst.push_back(sb.sync_byte);
		r = $urandom_range(0, 99);
		if (r < 45) v = sb.src_a;
		else if (r < 85) v = sb.src_b;
		else if (r < 92) v = sb.sync_byte;
		else v = 8'($urandom);
		burst.push_back(v);
		r = $urandom_range(0, 99);
		if (r < 88) v = sb.local_addr;
		else if (r < 94) v = sb.sync_byte;
		else v = 8'($urandom);
		burst.push_back(v);
		if ($urandom_range(0, 1)) fn = sb.fn_codes[8*$urandom_range(0, 4) +: 8];
		else fn = 8'($urandom);
		burst.push_back(fn);
		burst.push_back(8'($urandom));
		if (sb.code_has_data(fn)) burst.push_back(8'($urandom));
		add_crc(first, $urandom_range(0, 99) < 12);
		if ($urandom_range(0, 99) < 5) begin
			repeat ($urandom_range(1, 3)) void'(burst.pop_back());
		end
	endfunction

	task automatic run_phase(logic [7:0] sync_v, logic [7:0] local_v, logic [7:0] src_a_v,
	                         logic [7:0] src_b_v, logic [39:0] codes_v, int unsigned budget);
		int unsigned stop_at;
		configure(sync_v, local_v, src_a_v, src_b_v, codes_v);
		stop_at = n_bytes + budget;
		while (n_bytes < stop_at) begin
			// occasional stretches with no idling on either side
			if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
			build_random_frame();
			send_burst();
		end
		no_gaps = 0;
	endtask

	initial begin
		logic [39:0] codes;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = '0;
		res_if.ready  = 1'b0;
		no_gaps       = 0;
		sink_stall    = 0;
		n_bytes       = 0;
		n_settings    = 0;
		quiet_cycles  = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part
		configure(D_SYNC, D_LOCAL, D_SRC_A, D_SRC_B, D_CODES);
		// good frame carrying a data byte
		burst = '{D_SYNC, D_SRC_A, D_LOCAL, 8'h06, 8'h20, 8'h7E};
		add_crc(0, 0);
		// bad source that is not the sync byte: back to hunting
		burst.push_back(D_SYNC);
		burst.push_back(8'h33);
		send_burst();
		// bad source equal to sync restarts, then bad target equal to sync
		// restarts again; the frame that follows has no data and is good
		burst = '{D_SYNC, D_SYNC, D_SRC_A, D_SYNC, D_SRC_B, D_LOCAL, 8'h03, 8'hFF};
		add_crc(3, 0);
		send_burst();
		// duplicated code needs data, data byte 0xFF, CRC damaged
		burst = '{D_SYNC, D_SRC_B, D_LOCAL, 8'h10, 8'h00, 8'hFF};
		add_crc(0, 1);
		// recovery ignores everything up to the next sync byte
		burst.push_back(8'h00);
		burst.push_back(D_SRC_A);
		send_burst();

		// random part: extremes first, then random settings
		run_phase(8'h00, 8'h00, 8'h00, 8'hFF, 40'h0, 150);
		run_phase(8'hFF, 8'hFF, 8'hFF, 8'hFF, {40{1'b1}}, 150);
		repeat (4) begin
			codes = 40'({$urandom, $urandom});
			if ($urandom_range(0, 1)) codes[31:24] = codes[7:0];
			run_phase(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), codes, 150);
		end

		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (sb.expected_frames.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes under %0d register settings.", n_bytes, n_settings);
		$display("Frames reported: %0d with good CRC, %0d with bad CRC; %0d mismatches.",
		         sb.frames_good, sb.frames_bad, sb.errors);
		if (sb.errors == 0) begin
			$display("[crc16_addressed_frame_receiver_top] OK");
		end else begin
			$display("[crc16_addressed_frame_receiver_top] ERROR");
		end
		$finish;
	end

endmodule
